>>> rtl/core/swiglu_forward_unit_assert.svh
// Assertion macros for the SwiGLU forward unit.
// Used by the top level; expects signals named clk and arst_n in scope.
`ifndef SWIGLU_FORWARD_UNIT_ASSERT_SVH
`define SWIGLU_FORWARD_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SGU_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SGU_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/sgu_pkg.sv
// Shared constants, payload structs and rounding helper for the SwiGLU unit.
// No dependencies; used by every module of the block.
package sgu_pkg;

	localparam logic signed [16:0] ARG_LIMIT = 17'sd22528;
	localparam logic signed [17:0] LOG2E_Q16 = 18'sd94548;
	localparam logic signed [26:0] C0_Q24 = 27'sd16777216;
	localparam logic signed [26:0] C1_Q24 = 27'sd11629080;
	localparam logic signed [26:0] C2_Q24 = 27'sd4030332;
	localparam logic signed [26:0] C3_Q24 = 27'sd931204;
	localparam logic signed [26:0] C4_Q24 = 27'sd161365;
	localparam int DIV_STEPS = 33;

	typedef struct packed {
		logic [30:0] mag;
		logic        neg;
		logic        row_end;
	} side_t;

	typedef struct packed {
		logic [24:0]       p;
		logic signed [7:0] n;
	} exp_t;

	function automatic logic signed [26:0] rnd_q24(input logic signed [50:0] v);
		logic signed [50:0] t;
		t = v + 51'sd8388608;
		return t[50:24];
	endfunction

endpackage

>>> rtl/core/swiglu_forward_unit.sv
// SwiGLU forward unit, top level: product stages, stream ports and checks.
// Depends on sgu_pkg, sgu_exp, sgu_div and swiglu_forward_unit_assert.svh.
//
// Usage: each request on the slave stream carries one element pair. s_tdata holds
// gate in bits 15:0 and up in bits 31:16, both signed Q8.8; s_tlast marks the
// last element of a token row. Each request yields exactly one result on the
// master stream: m_tdata is silu(gate) * up in signed Q16.16 and m_tlast is the
// copied row flag. Results leave in request order.
// From acceptance to m_tvalid a request passes six stages for the clamp and the
// exponential polynomial, one to scale it, 33 for the bit-per-stage sigmoid
// divider and two for the final product and rounding.
// Throughput is one request per cycle while m_tready is high; every stage holds
// its own valid bit, so a request is taken whenever any slot down the pipe is
// free. When the receiver stalls the pipe fills up; s_tready falls only once all
// stages are full. Reset clears all valid bits; the block holds no other state.
`include "swiglu_forward_unit_assert.svh"

module swiglu_forward_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // gate [15:0], up [31:16]
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // product [31:0]
	output logic        m_tlast
);

	logic           exp_valid, exp_ready;
	sgu_pkg::exp_t  exp_data;
	sgu_pkg::side_t exp_side;
	logic           div_valid, div_ready;
	logic [32:0]    sig;
	sgu_pkg::side_t div_side;

	logic        v_s1, v_s2, rdy1, rdy2;
	logic [62:0] prod_s1;
	logic        neg_s1, last_s1;
	logic [31:0] res_s2;
	logic        last_s2;
	logic [63:0] sum;
	logic [31:0] mag;

	sgu_exp u_exp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.gate      ($signed(s_tdata[15:0])),
		.up        ($signed(s_tdata[31:16])),
		.row_end   (s_tlast),
		.out_valid (exp_valid),
		.out_ready (exp_ready),
		.out_exp   (exp_data),
		.out_side  (exp_side)
	);

	sgu_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (exp_valid),
		.in_ready  (exp_ready),
		.in_exp    (exp_data),
		.in_side   (exp_side),
		.out_valid (div_valid),
		.out_ready (div_ready),
		.sig       (sig),
		.out_side  (div_side)
	);

	assign rdy2      = !v_s2 || m_tready;
	assign rdy1      = !v_s1 || rdy2;
	assign div_ready = rdy1;

	always_comb begin
		sum = 64'(prod_s1) + 64'h0000_0000_8000_0000;
		mag = {1'b0, sum[62:32]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= div_valid;
			if (rdy2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1) begin
			prod_s1 <= sig[32] ? {div_side.mag, 32'd0} : (63'(div_side.mag) * 63'(sig[31:0]));
			neg_s1  <= div_side.neg;
			last_s1 <= div_side.row_end;
		end
		if (rdy2) begin
			res_s2  <= neg_s1 ? (32'd0 - mag) : mag;
			last_s2 <= last_s1;
		end
	end

	assign m_tvalid = v_s2;
	assign m_tdata  = res_s2;
	assign m_tlast  = last_s2;

	`SGU_ASSERT_IMP(a_ready_only_on_stall, !s_tready, m_tvalid && !m_tready, "input blocked without output stall")
	`SGU_ASSERT_IMP(a_exp_range, exp_valid, exp_data.p >= 25'd8388608, "polynomial result out of range")
	`SGU_ASSERT_IMP(a_sig_range, div_valid && sig[32], sig[31:0] == 32'd0, "sigmoid above one")
	`SGU_ASSERT_NXT(a_div_hold, div_valid && !div_ready, div_valid && $stable(sig), "divider output lost")

endmodule

>>> rtl/core/sgu_exp.sv
// Exponential stages: clamp, base-2 split and Horner polynomial for 2^f.
// Depends on sgu_pkg; also forms the magnitude product of gate and up.
module sgu_exp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic signed [15:0]   gate,
	input  logic signed [15:0]   up,
	input  logic                 row_end,
	output logic                 out_valid,
	input  logic                 out_ready,
	output sgu_pkg::exp_t        out_exp,
	output sgu_pkg::side_t       out_side
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;

	logic signed [31:0] z_s1;
	sgu_pkg::side_t     side_s1, side_s2, side_s3, side_s4, side_s5, side_s6;
	logic signed [23:0] f_s2, f_s3, f_s4;
	logic signed [7:0]  n_s2, n_s3, n_s4, n_s5, n_s6;
	logic signed [50:0] prod_s2, prod_s3, prod_s4, prod_s5;
	logic [24:0]        p_s6;

	logic signed [16:0] arg_neg, arg;
	logic signed [34:0] z_full;
	logic [15:0]        ag, au;
	logic [31:0]        m_full;
	logic [32:0]        t2;
	logic signed [23:0] f2;
	logic signed [7:0]  n2;
	logic signed [26:0] p3, p4, p5, p6;

	assign rdy6 = !v_s6 || out_ready;
	assign rdy5 = !v_s5 || rdy6;
	assign rdy4 = !v_s4 || rdy5;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign in_ready = rdy1;

	always_comb begin
		arg_neg = -$signed({gate[15], gate});
		if (arg_neg > sgu_pkg::ARG_LIMIT) begin
			arg = sgu_pkg::ARG_LIMIT;
		end else if (arg_neg < -sgu_pkg::ARG_LIMIT) begin
			arg = -sgu_pkg::ARG_LIMIT;
		end else begin
			arg = arg_neg;
		end
		z_full = 35'(arg) * 35'(sgu_pkg::LOG2E_Q16);
		ag = gate[15] ? (~gate + 16'd1) : gate;
		au = up[15] ? (~up + 16'd1) : up;
		m_full = ag * au;
	end

	always_comb begin
		t2 = 33'($signed({z_s1[31], z_s1})) + 33'h080800000;
		n2 = {~t2[31], t2[30:24]};
		f2 = {~t2[23], t2[22:0]};
	end

	assign p3 = sgu_pkg::C3_Q24 + sgu_pkg::rnd_q24(prod_s2);
	assign p4 = sgu_pkg::C2_Q24 + sgu_pkg::rnd_q24(prod_s3);
	assign p5 = sgu_pkg::C1_Q24 + sgu_pkg::rnd_q24(prod_s4);
	assign p6 = sgu_pkg::C0_Q24 + sgu_pkg::rnd_q24(prod_s5);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
			if (rdy6) v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1) begin
			z_s1         <= z_full[31:0];
			side_s1.mag  <= m_full[30:0];
			side_s1.neg  <= gate[15] ^ up[15];
			side_s1.row_end <= row_end;
		end
		if (rdy2) begin
			n_s2    <= n2;
			f_s2    <= f2;
			prod_s2 <= 51'(f2) * 51'(sgu_pkg::C4_Q24);
			side_s2 <= side_s1;
		end
		if (rdy3) begin
			n_s3    <= n_s2;
			f_s3    <= f_s2;
			prod_s3 <= 51'(f_s2) * 51'(p3);
			side_s3 <= side_s2;
		end
		if (rdy4) begin
			n_s4    <= n_s3;
			f_s4    <= f_s3;
			prod_s4 <= 51'(f_s3) * 51'(p4);
			side_s4 <= side_s3;
		end
		if (rdy5) begin
			n_s5    <= n_s4;
			prod_s5 <= 51'(f_s4) * 51'(p5);
			side_s5 <= side_s4;
		end
		if (rdy6) begin
			n_s6    <= n_s5;
			p_s6    <= p6[24:0];
			side_s6 <= side_s5;
		end
	end

	assign out_valid   = v_s6;
	assign out_exp.p   = p_s6;
	assign out_exp.n   = n_s6;
	assign out_side    = side_s6;

endmodule

>>> rtl/core/sgu_div.sv
// Sigmoid stages: scales 2^f by 2^n and divides 2^56 by 2^24 + e, one bit a stage.
// Depends on sgu_pkg; produces the sigmoid in unsigned Q1.32.
module sgu_div (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  sgu_pkg::exp_t   in_exp,
	input  sgu_pkg::side_t  in_side,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [32:0]     sig,
	output sgu_pkg::side_t  out_side
);

	localparam int NS = sgu_pkg::DIV_STEPS;

	logic                 v_s   [0:NS];
	logic                 rdy   [0:NS+1];
	logic [57:0]          d_s   [0:NS];
	logic [57:0]          rem_s [0:NS];
	logic [32:0]          num_s [0:NS];
	logic [32:0]          q_s   [0:NS];
	logic                 zero_s[0:NS];
	sgu_pkg::side_t       side_s[0:NS];

	logic [7:0]  k;
	logic [25:0] e;
	logic [57:0] d_c;
	logic [57:0] num_c;

	always_comb begin
		k = 8'(-in_exp.n);
		e = 26'd0;
		if (!in_exp.n[7]) begin
			d_c = (58'd1 << 24) + (58'(in_exp.p) << in_exp.n[5:0]);
		end else begin
			if (k < 8'd32) begin
				e = (26'(in_exp.p) + (26'd1 << (k[4:0] - 5'd1))) >> k[4:0];
			end
			d_c = (58'd1 << 24) + 58'(e);
		end
		num_c = (58'd1 << 56) + (d_c >> 1);
	end

	assign rdy[NS+1] = out_ready;
	assign in_ready  = rdy[0];

	for (genvar i = 0; i <= NS; i++) begin : g_rdy
		assign rdy[i] = !v_s[i] || rdy[i+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (rdy[0]) begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[0]) begin
			d_s[0]    <= d_c;
			rem_s[0]  <= {33'd0, num_c[57:33]};
			num_s[0]  <= num_c[32:0];
			q_s[0]    <= 33'd0;
			zero_s[0] <= (in_exp.n > 8'sd32);
			side_s[0] <= in_side;
		end
	end

	for (genvar i = 0; i < NS; i++) begin : g_step
		logic [58:0] rs;
		logic        ge;
		logic [58:0] rn;

		always_comb begin
			rs = {rem_s[i], num_s[i][32]};
			ge = rs >= {1'b0, d_s[i]};
			rn = ge ? (rs - {1'b0, d_s[i]}) : rs;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (rdy[i+1]) begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[i+1]) begin
				d_s[i+1]    <= d_s[i];
				rem_s[i+1]  <= rn[57:0];
				num_s[i+1]  <= {num_s[i][31:0], 1'b0};
				q_s[i+1]    <= {q_s[i][31:0], ge};
				zero_s[i+1] <= zero_s[i];
				side_s[i+1] <= side_s[i];
			end
		end
	end

	assign out_valid = v_s[NS];
	assign sig       = zero_s[NS] ? 33'd0 : q_s[NS];
	assign out_side  = side_s[NS];

endmodule

>>> verif/swiglu_forward_unit_checker.sv
// Checker for the SwiGLU forward unit: watches both streams, predicts each result
// from the accepted request and compares it with what leaves the block.
// Depends only on the port layout of swiglu_forward_unit.
`timescale 1ns / 100ps

module swiglu_forward_unit_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [31:0] s_tdata,   // gate [15:0], up [31:16]
	input  logic        s_tlast,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,   // product [31:0]
	input  logic        m_tlast,
	output int          errors,
	output int          pending
);

	typedef struct packed {
		logic [31:0] product;
		logic        row_end;
	} swiglu_result_t;

	swiglu_result_t expected_results[$];

	function automatic longint round_q24(input longint v);
		return (v + 64'sd8388608) >>> 24;
	endfunction

	function automatic logic [63:0] sigmoid_q32(input logic signed [15:0] gate);
		longint a, z, n, f, p;
		logic [63:0] d, e;
		a = -longint'(gate);
		if (a > 22528) a = 22528;
		if (a < -22528) a = -22528;
		z = a * 94548;
		n = (z + 64'sd8388608) >>> 24;
		f = z - n * 64'sd16777216;
		p = 931204 + round_q24(f * 161365);
		p = 4030332 + round_q24(f * p);
		p = 11629080 + round_q24(f * p);
		p = 16777216 + round_q24(f * p);
		if (n > 32) return 64'd0;
		if (n >= 0) begin
			d = 64'd16777216 + (64'(p) << n);
		end else begin
			e = 0;
			if (-n < 32) e = (64'(p) + (64'd1 << (-n - 1))) >> (-n);
			d = 64'd16777216 + e;
		end
		return ((64'd1 << 56) + d / 2) / d;
	endfunction

	function automatic logic [31:0] swiglu_product(input logic signed [15:0] gate,
			input logic signed [15:0] up);
		logic [63:0] ag, au, mag;
		ag = gate < 0 ? 64'(-longint'(gate)) : 64'(gate);
		au = up < 0 ? 64'(-longint'(up)) : 64'(up);
		mag = (ag * au * sigmoid_q32(gate) + (64'd1 << 31)) >> 32;
		return ((gate < 0) != (up < 0)) ? 32'(0 - mag) : mag[31:0];
	endfunction

	assign pending = expected_results.size();

	always @(posedge clk or negedge arst_n) begin
		swiglu_result_t want;
		if (!arst_n) begin
			errors = 0;
			expected_results.delete();
		end else begin
			if (s_tvalid && s_tready)
				expected_results.push_back({swiglu_product(s_tdata[15:0], s_tdata[31:16]),
					s_tlast});
			if (m_tvalid && m_tready) begin
				if (expected_results.size() == 0) begin
					$error("result with no request outstanding: product %h", m_tdata);
					errors++;
				end else begin
					want = expected_results.pop_front();
					if (m_tdata !== want.product) begin
						$error("product: expected %h, actual %h", want.product, m_tdata);
						errors++;
					end
					if (m_tlast !== want.row_end) begin
						$error("row_end_out: expected %b, actual %b", want.row_end, m_tlast);
						errors++;
					end
				end
			end
		end
	end

endmodule

>>> verif/swiglu_forward_unit_test.sv
// Testbench top for the SwiGLU forward unit: directed and random element pairs with
// bursty input, a stalling receiver and a long hold-off, then the verdict.
// Depends on swiglu_forward_unit and swiglu_forward_unit_checker.
`timescale 1ns / 100ps

module swiglu_forward_unit_test;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;   // gate [15:0], up [31:16]
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;   // product [31:0]
	logic        m_tlast;
	int          errors;
	int          pending;
	int          stall_mode;
	int          hold_count;
	int          idle_cycles;
	bit          stimulus_done;

	localparam int IDLE_LIMIT = 5000;

	swiglu_forward_unit DUT (.*);

	swiglu_forward_unit_checker checker_i (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(negedge clk) begin
		if (hold_count > 0) begin
			m_tready <= 1'b0;
			hold_count <= hold_count - 1;
		end else begin
			case (stall_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= 1'($urandom_range(1, 0));
				default: m_tready <= ($urandom_range(3, 0) == 0);
			endcase
		end
	end

	always @(posedge clk) begin
		if (!arst_n || stimulus_done || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	task automatic send_pair(input logic [15:0] gate, input logic [15:0] up, input logic last);
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= {up, gate};
		s_tlast <= last;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic pause_sender(input int cycles);
		@(negedge clk);
		s_tvalid <= 1'b0;
		repeat (cycles) @(negedge clk);
	endtask

	function automatic logic [15:0] random_gate();
		case ($urandom_range(3, 0))
			0: return 16'($urandom_range(2048, 0) - 1024);
			1: return 16'($urandom_range(8192, 0) - 4096);
			2: return 16'($urandom_range(24000, 0) - 12000);
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic random_phase(input int count, input int mode);
		int left;
		int burst;
		stall_mode = mode;
		left = count;
		while (left > 0) begin
			burst = $urandom_range(40, 1);
			while (burst > 0 && left > 0) begin
				send_pair(random_gate(), 16'($urandom), 1'($urandom_range(1, 0)));
				burst--;
				left--;
			end
			if ($urandom_range(3, 0) != 0) pause_sender($urandom_range(12, 0));
		end
	endtask

	initial begin
		logic [15:0] gates[13] = '{16'h8000, 16'h7FFF, 16'h0000, 16'h0001, 16'hFFFF,
			16'd22528, -16'sd22528, 16'd22529, -16'sd22529, 16'h0100, 16'hFF00,
			16'h5555, 16'hAAAA};
		logic [15:0] ups[4] = '{16'h7FFF, 16'h8000, 16'h0001, 16'hFFFF};
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		m_tready = 1'b0;
		stall_mode = 0;
		hold_count = 0;
		stimulus_done = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (gates[i]) send_pair(gates[i], ups[i % 4], i[0]);
		send_pair(16'h8000, 16'h8000, 1'b1);
		send_pair(16'h7FFF, 16'h7FFF, 1'b0);
		pause_sender(3);

		random_phase(400, 0);
		random_phase(400, 1);
		pause_sender(0);
		hold_count <= 300;
		random_phase(300, 2);
		random_phase(600, 1);
		pause_sender(0);

		wait (pending == 0);
		stimulus_done = 1'b1;
		repeat (60) @(posedge clk);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
